// ----- hdl/lkvc_pkg.sv -----
// Shared types and constants of the LRU key-value cache.
// No dependencies; every module of the block imports this package.
`default_nettype none

package lkvc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W   = IDX_W;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CFG_W    = 5;
    localparam int DATA_W   = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
    } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/lkvc_in_reg.sv -----
// Input register of the LRU key-value cache: holds one request item.
// Depends on lkvc_pkg for the request type.
`default_nettype none

module lkvc_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lkvc_pkg::req_t in_req,
    input  wire logic          take,
    output logic               req_valid,
    output lkvc_pkg::req_t     req
);
    import lkvc_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            req_reg <= in_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

// ----- hdl/lkvc_engine.sv -----
// Entry store, recency ranks and the lookup, fill and eviction logic of the cache.
// Depends on lkvc_pkg; holds the capacity register written over the config channel.
`default_nettype none

module lkvc_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_write,
    input  wire logic [lkvc_pkg::CFG_W-1:0] cfg_data,
    input  wire logic           advance,
    input  wire lkvc_pkg::req_t req,
    output lkvc_pkg::rsp_t      rsp
);
    import lkvc_pkg::*;

    logic signed [DATA_W-1:0] key_mem [CAPACITY];
    logic signed [DATA_W-1:0] data_mem [CAPACITY];
    logic [CAPACITY-1:0]      valid_reg;
    logic [CAPACITY-1:0]      valid_next;
    logic [RANK_W-1:0]        rank_reg [CAPACITY];
    logic [RANK_W-1:0]        rank_next [CAPACITY];
    logic [CNT_W-1:0]         occ_reg;
    logic [CNT_W-1:0]         occ_next;
    logic [CFG_W-1:0]         cap_reg;

    logic [CNT_W-1:0]  eff_cap;
    logic              found;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_any;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  lru_idx;
    logic              lru_any;
    logic              use_free;
    logic              do_promote;
    logic              fresh;
    logic              write_key;
    logic              write_data;
    logic [IDX_W-1:0]  tgt_idx;
    logic [RANK_W-1:0] tgt_rank;

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(cap_reg) > CAPACITY) begin
            eff_cap = CNT_W'(CAPACITY);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    // The least recent valid entry carries the rank occupied count minus one.
    always_comb begin
        found    = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        lru_any  = 1'b0;
        lru_idx  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!found && valid_reg[i] && key_mem[i] == req.key) begin
                found   = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!free_any && !valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (!lru_any && valid_reg[i]
                    && (CNT_W'(rank_reg[i]) + CNT_W'(1)) == occ_reg) begin
                lru_any = 1'b1;
                lru_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        use_free   = (occ_reg < eff_cap) && free_any;
        do_promote = 1'b0;
        fresh      = 1'b0;
        write_key  = 1'b0;
        write_data = 1'b0;
        tgt_idx    = hit_idx;
        rsp.hit         = found;
        rsp.read_value  = '0;
        rsp.evicted     = 1'b0;
        rsp.evicted_key = '0;
        occ_next   = occ_reg;
        valid_next = valid_reg;
        if (req.req_type == REQ_GET) begin
            if (found) begin
                rsp.read_value = data_mem[hit_idx];
                do_promote     = 1'b1;
            end else begin
                rsp.read_value = MISS_VALUE;
            end
        end else if (found) begin
            write_data = 1'b1;
            do_promote = 1'b1;
        end else if (use_free || !lru_any) begin
            tgt_idx             = use_free ? free_idx : '0;
            write_key           = 1'b1;
            write_data          = 1'b1;
            do_promote          = 1'b1;
            fresh               = 1'b1;
            valid_next[tgt_idx] = 1'b1;
            occ_next            = use_free ? occ_reg + CNT_W'(1) : CNT_W'(1);
        end else begin
            tgt_idx         = lru_idx;
            write_key       = 1'b1;
            write_data      = 1'b1;
            do_promote      = 1'b1;
            rsp.evicted     = 1'b1;
            rsp.evicted_key = key_mem[lru_idx];
        end
        tgt_rank = rank_reg[tgt_idx];
        for (int i = 0; i < CAPACITY; i++) begin
            rank_next[i] = rank_reg[i];
            if (do_promote) begin
                if (IDX_W'(i) == tgt_idx) begin
                    rank_next[i] = '0;
                end else if (valid_reg[i] && (fresh || rank_reg[i] < tgt_rank)) begin
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CFG_RESET;
            for (int i = 0; i < CAPACITY; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_write) begin
                cap_reg <= cfg_data;
            end
            if (advance) begin
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
                for (int i = 0; i < CAPACITY; i++) begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && write_key) begin
            key_mem[tgt_idx] <= req.key;
        end
        if (advance && write_data) begin
            data_mem[tgt_idx] <= req.value;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lkvc_out_reg.sv -----
// Result register of the LRU key-value cache: holds one result item until taken.
// Depends on lkvc_pkg for the result type.
`default_nettype none

module lkvc_out_reg (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire lkvc_pkg::rsp_t rsp,
    output logic                can_load,
    output logic                out_valid,
    input  wire logic           out_ready,
    output lkvc_pkg::rsp_t      out_rsp
);
    import lkvc_pkg::*;

    logic valid_reg;
    logic valid_next;
    rsp_t rsp_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : ((valid_reg && out_ready) ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rsp_reg <= rsp;
        end
    end

    assign out_valid = valid_reg;
    assign out_rsp   = rsp_reg;

endmodule

`default_nettype wire

// ----- hdl/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: input register, engine and result register.
// Depends on lkvc_pkg, lkvc_in_reg, lkvc_engine and lkvc_out_reg.
//
// A fully associative store of 16 key-value entries with least-recently-used
// replacement. Each request item is a get or a put and gives exactly one result
// item. The block accepts one item per cycle when the result side keeps up; an
// item is held in the input register, where the key is compared with all entries
// at once and the ranks are updated, and its result is loaded into the result
// register when that register can take it. The capacity register takes effect
// from the next request and should be written only while no request is in
// flight. After reset the store is empty and usable at once.
`default_nettype none

module lru_key_value_cache (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // key [31:0], value [63:32]
    input  wire logic        s_tuser,   // req_type [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // read_value [31:0], evicted_key [63:32]
    output logic [1:0]       m_tuser,   // hit [0], evicted [1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data   // capacity_in_use [4:0]
);
    import lkvc_pkg::*;

    req_t in_req;
    req_t req;
    rsp_t rsp;
    rsp_t out_rsp;
    logic req_valid;
    logic can_load;
    logic advance;

    assign in_req.req_type = s_tuser;
    assign in_req.key      = s_tdata[DATA_W-1:0];
    assign in_req.value    = s_tdata[2*DATA_W-1:DATA_W];

    assign advance   = req_valid && can_load;
    assign cfg_ready = 1'b1;

    lkvc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .take      (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    lkvc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .req       (req),
        .rsp       (rsp)
    );

    lkvc_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance),
        .rsp       (rsp),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rsp   (out_rsp)
    );

    assign m_tdata = {out_rsp.evicted_key, out_rsp.read_value};
    assign m_tuser = {out_rsp.evicted, out_rsp.hit};

endmodule

`default_nettype wire
